// ===== src/ntpc_pkg.sv =====
`timescale 1ns / 1ps

package ntpc_pkg;

    // Command codes carried by each input beat
    localparam logic [1:0] CMD_POLL     = 2'd0;
    localparam logic [1:0] CMD_SEC_TICK = 2'd1;
    localparam logic [1:0] CMD_MS_TICK  = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_REPLY_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UTC_OFFSET    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EPOCH_OFFSET  = 2'd3;

    // Configuration reset values
    localparam logic [15:0] RST_REPLY_TIMEOUT = 16'd4000;
    localparam logic [2:0]  RST_MAX_RETRIES   = 3'd5;
    localparam logic [4:0]  RST_UTC_OFFSET    = 5'd2;
    localparam logic [31:0] RST_EPOCH_OFFSET  = 32'd3723753600;

    // Time constants
    localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
    localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
    localparam logic [5:0]  LAST_SEC     = 6'd59;
    localparam logic [5:0]  LAST_MIN     = 6'd59;
    localparam logic [4:0]  LAST_HOUR    = 5'd23;
    localparam logic [2:0]  LAST_DAY     = 3'd7;
    localparam logic [2:0]  FIRST_DAY    = 3'd1;
    localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;
    localparam logic [5:0]  HOURS_PER_DAY = 6'd24;

    // Reciprocals for exact floor division by constants
    // t/86400 = (t>>7)/675, dividend 25 bits, shift 35
    localparam logic [25:0] RECIP_DAY      = 26'd50903317;
    localparam int          RECIP_DAY_SH   = 35;
    // r/3600 = (r>>4)/225, dividend 13 bits, shift 21
    localparam logic [13:0] RECIP_HOUR     = 14'd9321;
    localparam int          RECIP_HOUR_SH  = 21;
    // r/60 = (r>>2)/15, dividend 10 bits, shift 14
    localparam logic [10:0] RECIP_MIN      = 11'd1093;
    localparam int          RECIP_MIN_SH   = 14;

    typedef enum logic [1:0] {
        SEQ_SEND     = 2'd0,
        SEQ_WAIT     = 2'd1,
        SEQ_MIDNIGHT = 2'd2
    } seq_state_t;

    // One converted beat as seen by the state update stage
    typedef struct packed {
        logic [1:0] cmd;
        logic       reply;
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [2:0] day;
    } conv_item_t;

endpackage

// ===== src/ntpc_conv.sv =====
`timescale 1ns / 1ps

// Pipelined split of an NTP timestamp into local h/m/s and weekday.
module ntpc_conv
    import ntpc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic        reply,
    input  logic [31:0] ntp,
    input  logic [31:0] epoch_offset,
    input  logic [4:0]  utc_offset,
    output logic        item_valid,
    output conv_item_t  item,
    input  logic        take
);

    localparam int NSTG = 7;

    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] rdy;
    logic [1:0]      cmd_reg   [NSTG];
    logic            reply_reg [NSTG];

    // stage payloads
    logic [31:0] s1_t_reg;
    logic [31:0] s2_t_reg;
    logic [15:0] s2_q_reg;
    logic [16:0] s3_rem_reg;
    logic [2:0]  s3_wd_reg;
    logic [16:0] s4_rem_reg;
    logic [2:0]  s4_wd_reg;
    logic [4:0]  s4_hrs_reg;
    logic [11:0] s5_rem_reg;
    logic [4:0]  s5_hour_reg;
    logic [2:0]  s5_day_reg;
    logic [11:0] s6_rem_reg;
    logic [5:0]  s6_min_reg;
    logic [4:0]  s6_hour_reg;
    logic [2:0]  s6_day_reg;
    logic [5:0]  s7_sec_reg;
    logic [5:0]  s7_min_reg;
    logic [4:0]  s7_hour_reg;
    logic [2:0]  s7_day_reg;

    logic [50:0] day_prod;
    logic [31:0] rem_day;
    logic [5:0]  q_sum;
    logic [3:0]  q_fold;
    logic [2:0]  q_mod7;
    logic [26:0] hour_prod;
    logic [16:0] rem_hour;
    logic [5:0]  h_local;
    logic [4:0]  hour_wrap;
    logic [1:0]  day_carry;
    logic [3:0]  wd_sum;
    logic [2:0]  wd_mod7;
    logic [20:0] min_prod;
    logic [11:0] sec_full;

    // ready ripples back from the consumer
    always_comb
    begin
        rdy[NSTG-1] = !v_reg[NSTG-1] || take;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign in_stall   = !rdy[0];
    assign item_valid = v_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= (i == 0) ? in_valid : v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NSTG; i++)
        begin
            if (rdy[i])
            begin
                cmd_reg[i]   <= (i == 0) ? cmd   : cmd_reg[i-1];
                reply_reg[i] <= (i == 0) ? reply : reply_reg[i-1];
            end
        end
    end

    // stage 2: day count by reciprocal multiply
    assign day_prod = 51'(s1_t_reg[31:7]) * 51'(RECIP_DAY);

    // stage 3: remainder within day, day count mod 7 (8 == 1 mod 7)
    assign rem_day = s2_t_reg - (32'(s2_q_reg) * 32'(SEC_PER_DAY));
    assign q_sum   = 6'(s2_q_reg[2:0]) + 6'(s2_q_reg[5:3]) + 6'(s2_q_reg[8:6])
                   + 6'(s2_q_reg[11:9]) + 6'(s2_q_reg[14:12]) + 6'(s2_q_reg[15]);
    assign q_fold  = 4'(q_sum[5:3]) + 4'(q_sum[2:0]);
    assign q_mod7  = (q_fold >= 4'(DAYS_PER_WEEK)) ? 3'(q_fold - 4'(DAYS_PER_WEEK))
                                                   : q_fold[2:0];

    // stage 4: hours of day
    assign hour_prod = 27'(s3_rem_reg[16:4]) * 27'(RECIP_HOUR);

    // stage 5: remainder within hour, zone shift with day carry
    assign rem_hour = s4_rem_reg - (17'(s4_hrs_reg) * 17'(SEC_PER_HOUR));
    assign h_local  = 6'(s4_hrs_reg) + 6'(utc_offset);

    always_comb
    begin
        if (h_local >= 6'(2 * HOURS_PER_DAY))
        begin
            hour_wrap = 5'(h_local - 6'(2 * HOURS_PER_DAY));
            day_carry = 2'd2;
        end
        else if (h_local >= HOURS_PER_DAY)
        begin
            hour_wrap = 5'(h_local - HOURS_PER_DAY);
            day_carry = 2'd1;
        end
        else
        begin
            hour_wrap = h_local[4:0];
            day_carry = 2'd0;
        end
    end

    assign wd_sum  = 4'(s4_wd_reg) + 4'(day_carry);
    assign wd_mod7 = (wd_sum >= 4'(DAYS_PER_WEEK)) ? 3'(wd_sum - 4'(DAYS_PER_WEEK))
                                                   : wd_sum[2:0];

    // stage 6: minutes
    assign min_prod = 21'(s5_rem_reg[11:2]) * 21'(RECIP_MIN);

    // stage 7: seconds
    assign sec_full = s6_rem_reg - (12'(s6_min_reg) * 12'(SEC_PER_MIN));

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            s1_t_reg <= ntp - epoch_offset;
        end
        if (rdy[1])
        begin
            s2_t_reg <= s1_t_reg;
            s2_q_reg <= day_prod[RECIP_DAY_SH+15:RECIP_DAY_SH];
        end
        if (rdy[2])
        begin
            s3_rem_reg <= rem_day[16:0];
            s3_wd_reg  <= q_mod7;
        end
        if (rdy[3])
        begin
            s4_rem_reg <= s3_rem_reg;
            s4_wd_reg  <= s3_wd_reg;
            s4_hrs_reg <= hour_prod[RECIP_HOUR_SH+4:RECIP_HOUR_SH];
        end
        if (rdy[4])
        begin
            s5_rem_reg  <= rem_hour[11:0];
            s5_hour_reg <= hour_wrap;
            s5_day_reg  <= wd_mod7 + FIRST_DAY;
        end
        if (rdy[5])
        begin
            s6_rem_reg  <= s5_rem_reg;
            s6_min_reg  <= min_prod[RECIP_MIN_SH+5:RECIP_MIN_SH];
            s6_hour_reg <= s5_hour_reg;
            s6_day_reg  <= s5_day_reg;
        end
        if (rdy[6])
        begin
            s7_sec_reg  <= sec_full[5:0];
            s7_min_reg  <= s6_min_reg;
            s7_hour_reg <= s6_hour_reg;
            s7_day_reg  <= s6_day_reg;
        end
    end

    assign item.cmd   = cmd_reg[NSTG-1];
    assign item.reply = reply_reg[NSTG-1];
    assign item.sec   = s7_sec_reg;
    assign item.min   = s7_min_reg;
    assign item.hour  = s7_hour_reg;
    assign item.day   = s7_day_reg;

endmodule

// ===== src/ntp_synced_time_of_day_clock_core.sv =====
`timescale 1ns / 1ps

// Time-of-day clock with weekday, set from NTP reply timestamps. Every input
// beat carries a command: poll (steps the request / wait / retry / wait-for-
// midnight sequencer and, on a reply while waiting, loads the time), second
// tick, or millisecond tick (advances the saturating reply timeout counter).
// Each input beat yields exactly one output beat showing the clock state after
// that step; request_sent flags the poll that issued a request. Throughput is
// one beat per clock while the output is not stalled. The accepting edge
// loads the first of seven stages that split the timestamp (epoch subtract,
// day divide, day remainder and weekday, hour divide, zone shift, minute
// divide, seconds), and the combinational state update then loads the result
// register, which drives the outputs, from the seventh stage. A stalled output
// holds back the pipeline, and the input stalls once every stage is full.
// Config registers are written through cfg_write/cfg_index/cfg_data and must
// only change while the block is idle.
module ntp_synced_time_of_day_clock_core
    import ntpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // config write port
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            cmd,
    input  logic                  reply_ready,
    input  logic [31:0]           ntp_seconds,

    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  request_sent,
    output logic [5:0]            second,
    output logic [5:0]            minute,
    output logic [4:0]            hour,
    output logic [2:0]            weekday,
    output logic                  time_valid
);

    // config
    logic [15:0] reply_timeout_reg;
    logic [2:0]  max_retries_reg;
    logic [4:0]  utc_offset_reg;
    logic [31:0] epoch_offset_reg;

    // conversion pipeline hand-off
    logic        item_valid;
    conv_item_t  item;
    logic        take;

    // sequencer and clock state
    seq_state_t  seq_reg,      seq_next;
    logic [2:0]  retry_reg,    retry_next;
    logic [15:0] elapsed_reg,  elapsed_next;
    logic [5:0]  sec_reg,      sec_next;
    logic [5:0]  min_reg,      min_next;
    logic [4:0]  hour_reg,     hour_next;
    logic [2:0]  day_reg,      day_next;
    logic        midnight_reg, midnight_next;
    logic        tvalid_reg,   tvalid_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic        sent_reg,      sent_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reply_timeout_reg <= RST_REPLY_TIMEOUT;
            max_retries_reg   <= RST_MAX_RETRIES;
            utc_offset_reg    <= RST_UTC_OFFSET;
            epoch_offset_reg  <= RST_EPOCH_OFFSET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_REPLY_TIMEOUT: reply_timeout_reg <= cfg_data[15:0];
                REG_MAX_RETRIES:   max_retries_reg   <= cfg_data[2:0];
                REG_UTC_OFFSET:    utc_offset_reg    <= cfg_data[4:0];
                REG_EPOCH_OFFSET:  epoch_offset_reg  <= cfg_data[31:0];
                default:           ;
            endcase
        end
    end

    ntpc_conv u_conv (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .reply        (reply_ready),
        .ntp          (ntp_seconds),
        .epoch_offset (epoch_offset_reg),
        .utc_offset   (utc_offset_reg),
        .item_valid   (item_valid),
        .item         (item),
        .take         (take)
    );

    // A beat is applied when the result register is free or being emptied.
    // State only moves on take, so it holds steady while a result is stalled.
    assign take = item_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        seq_next      = seq_reg;
        retry_next    = retry_reg;
        elapsed_next  = elapsed_reg;
        sec_next      = sec_reg;
        min_next      = min_reg;
        hour_next     = hour_reg;
        day_next      = day_reg;
        midnight_next = midnight_reg;
        tvalid_next   = tvalid_reg;
        sent_next     = sent_reg;

        if (take)
        begin
            sent_next = 1'b0;
            case (item.cmd)
                CMD_POLL:
                begin
                    unique case (seq_reg)
                        SEQ_SEND:
                        begin
                            sent_next    = 1'b1;
                            seq_next     = SEQ_WAIT;
                            elapsed_next = '0;
                        end
                        SEQ_WAIT:
                        begin
                            if (item.reply)
                            begin
                                // reply: take the precomputed local time
                                seq_next    = SEQ_MIDNIGHT;
                                sec_next    = item.sec;
                                min_next    = item.min;
                                hour_next   = item.hour;
                                day_next    = item.day;
                                tvalid_next = 1'b1;
                            end
                            else if (elapsed_reg > reply_timeout_reg)
                            begin
                                if (retry_reg != '1)
                                begin
                                    retry_next = retry_reg + 3'd1;
                                end
                                seq_next = (retry_reg < max_retries_reg) ? SEQ_SEND
                                                                         : SEQ_MIDNIGHT;
                            end
                        end
                        SEQ_MIDNIGHT:
                        begin
                            if (midnight_reg)
                            begin
                                retry_next    = '0;
                                seq_next      = SEQ_SEND;
                                midnight_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            seq_next = SEQ_SEND;
                        end
                    endcase
                end
                CMD_SEC_TICK:
                begin
                    if (sec_reg >= LAST_SEC)
                    begin
                        sec_next = '0;
                        if (min_reg >= LAST_MIN)
                        begin
                            min_next = '0;
                            if (hour_reg >= LAST_HOUR)
                            begin
                                hour_next     = '0;
                                midnight_next = 1'b1;
                                day_next      = (day_reg >= LAST_DAY) ? FIRST_DAY
                                                                      : day_reg + 3'd1;
                            end
                            else
                            begin
                                hour_next = hour_reg + 5'd1;
                            end
                        end
                        else
                        begin
                            min_next = min_reg + 6'd1;
                        end
                    end
                    else
                    begin
                        sec_next = sec_reg + 6'd1;
                    end
                end
                CMD_MS_TICK:
                begin
                    if (elapsed_reg != '1)
                    begin
                        elapsed_next = elapsed_reg + 16'd1;
                    end
                end
                default:
                begin
                    // unused command: state unchanged
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg      <= SEQ_SEND;
            retry_reg    <= '0;
            elapsed_reg  <= '0;
            sec_reg      <= '0;
            min_reg      <= '0;
            hour_reg     <= '0;
            day_reg      <= '0;
            midnight_reg <= 1'b0;
            tvalid_reg   <= 1'b0;
        end
        else
        begin
            seq_reg      <= seq_next;
            retry_reg    <= retry_next;
            elapsed_reg  <= elapsed_next;
            sec_reg      <= sec_next;
            min_reg      <= min_next;
            hour_reg     <= hour_next;
            day_reg      <= day_next;
            midnight_reg <= midnight_next;
            tvalid_reg   <= tvalid_next;
        end
    end

    // result register: valid flag plus request flag; time fields come
    // straight from the state, which is frozen while a beat waits
    assign out_valid_next = take || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sent_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sent_reg      <= sent_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign request_sent = sent_reg;
    assign second       = sec_reg;
    assign minute       = min_reg;
    assign hour         = hour_reg;
    assign weekday      = day_reg;
    assign time_valid   = tvalid_reg;

endmodule

// ===== bench/ntp_synced_time_of_day_clock_core_tb.sv =====
`timescale 1ns / 1ps

// Bench for the NTP-synced time-of-day clock. Every accepted input beat is
// run through a cycle-free model of the clock (sequencer, tick counters, reply
// loader) kept in tod_tracker; each output beat must match the oldest
// predicted time-of-day snapshot in order.
module ntp_synced_time_of_day_clock_core_tb
    import ntpc_pkg::*;
();

    // No package name exists for the spare command code
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int DAY_SECONDS = 86400;

    // One output beat: request flag plus the clock state after the step
    typedef struct packed {
        logic       sent;
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hr;
        logic [2:0] wday;
        logic       locked;
    } tod_t;

    // Mirror of the clock: config copy, sequencer, counters, and the queue
    // of time-of-day snapshots still owed by the block.
    class tod_tracker;
        logic [15:0] timeout_ms;
        logic [2:0]  retry_limit;
        logic [4:0]  zone_hours;
        logic [31:0] epoch_base;

        seq_state_t  seq;
        logic [2:0]  retries;
        logic [15:0] ms_count;
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hr;
        logic [2:0]  wday;
        logic        rollover;
        logic        locked;

        tod_t        expected_q[$];
        int          mismatches;

        function new();
            timeout_ms  = RST_REPLY_TIMEOUT;
            retry_limit = RST_MAX_RETRIES;
            zone_hours  = RST_UTC_OFFSET;
            epoch_base  = RST_EPOCH_OFFSET;
            seq         = SEQ_SEND;
            retries     = '0;
            ms_count    = '0;
            sec         = '0;
            min         = '0;
            hr          = '0;
            wday        = '0;
            rollover    = 1'b0;
            locked      = 1'b0;
            mismatches  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_REPLY_TIMEOUT: timeout_ms  = val[15:0];
                REG_MAX_RETRIES:   retry_limit = val[2:0];
                REG_UTC_OFFSET:    zone_hours  = val[4:0];
                REG_EPOCH_OFFSET:  epoch_base  = val;
                default: ;
            endcase
        endfunction

        // Step the clock by one accepted input beat and queue the snapshot
        function void note_beat(logic [1:0] op, logic reply, logic [31:0] stamp);
            tod_t        snap;
            logic        waiting;
            logic [2:0]  old_retries;
            logic [31:0] t;
            int unsigned h;
            int unsigned wd;

            snap.sent = 1'b0;
            case (op)
                CMD_POLL:
                begin
                    waiting = (seq == SEQ_WAIT);
                    case (seq)
                        SEQ_SEND:
                        begin
                            snap.sent = 1'b1;
                            seq = SEQ_WAIT;
                            ms_count = '0;
                        end
                        SEQ_WAIT:
                        begin
                            // reply wins over a pending timeout
                            if (reply)
                                seq = SEQ_MIDNIGHT;
                            else if (ms_count > timeout_ms)
                            begin
                                old_retries = retries;
                                if (retries != 3'd7)
                                    retries = retries + 3'd1;
                                seq = (old_retries < retry_limit) ? SEQ_SEND : SEQ_MIDNIGHT;
                            end
                        end
                        SEQ_MIDNIGHT:
                        begin
                            if (rollover)
                            begin
                                retries = '0;
                                seq = SEQ_SEND;
                                rollover = 1'b0;
                            end
                        end
                        default: seq = SEQ_SEND;
                    endcase
                    if (waiting && reply)
                    begin
                        // split NTP seconds into local h/m/s and weekday
                        t = stamp - epoch_base;
                        h = (t % 32'd86400) / 32'd3600 + zone_hours;
                        wd = (t % 32'd604800) / 32'd86400 + h / 24;
                        sec = t % 32'd60;
                        min = (t % 32'd3600) / 32'd60;
                        hr = h % 24;
                        wday = wd % 7 + 1;
                        locked = 1'b1;
                    end
                end
                CMD_SEC_TICK:
                begin
                    if (sec != 6'd59)
                        sec = sec + 6'd1;
                    else
                    begin
                        sec = '0;
                        if (min != 6'd59)
                            min = min + 6'd1;
                        else
                        begin
                            min = '0;
                            if (hr != 5'd23)
                                hr = hr + 5'd1;
                            else
                            begin
                                hr = '0;
                                rollover = 1'b1;
                                wday = (wday == 3'd7) ? 3'd1 : wday + 3'd1;
                            end
                        end
                    end
                end
                CMD_MS_TICK:
                begin
                    if (ms_count != 16'hFFFF)
                        ms_count = ms_count + 16'd1;
                end
                default: ;
            endcase
            snap.sec = sec;
            snap.min = min;
            snap.hr = hr;
            snap.wday = wday;
            snap.locked = locked;
            expected_q.push_back(snap);
        endfunction

        function void check_beat(tod_t got);
            tod_t want;

            if (expected_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t: output beat with nothing outstanding: %s%0d %0d:%0d:%0d %s%0d %s%0d",
                             $time, "sent=", got.sent, got.hr, got.min, got.sec,
                             "wd=", got.wday, "v=", got.locked);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
            begin
                if (mismatches < 10)
                begin
                    $display("%0t: expected sent=%0d %0d:%0d:%0d wd=%0d v=%0d",
                             $time, want.sent, want.hr, want.min, want.sec,
                             want.wday, want.locked);
                    $display("%0t:   actual sent=%0d %0d:%0d:%0d wd=%0d v=%0d",
                             $time, got.sent, got.hr, got.min, got.sec,
                             got.wday, got.locked);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            cmd = CMD_POLL;
    logic                  reply_ready = 1'b0;
    logic [31:0]           ntp_seconds = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  request_sent;
    logic [5:0]            second;
    logic [5:0]            minute;
    logic [4:0]            hour;
    logic [2:0]            weekday;
    logic                  time_valid;

    tod_tracker tracker;

    // quiet: no idling on either side
    // hold_req: ask the receiver for one long back-pressure stretch
    bit quiet = 1'b0;
    bit hold_req = 1'b0;

    ntp_synced_time_of_day_clock_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .reply_ready  (reply_ready),
        .ntp_seconds  (ntp_seconds),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .request_sent (request_sent),
        .second       (second),
        .minute       (minute),
        .hour         (hour),
        .weekday      (weekday),
        .time_valid   (time_valid)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #1_000_000;
        $display("FAILURE");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off on request so the
    // pipeline backs up and the input side has to stall.
    initial
    begin
        int hold_left;

        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = 64;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !quiet && ($urandom_range(99) < 28);
        end
    end

    // Output beat monitor, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_beat({request_sent, second, minute, hour, weekday, time_valid});
    end

    // Offer one input beat and hold it until accepted. Valid is only
    // dropped during an idle gap, never between back-to-back beats.
    task automatic push_beat(logic [1:0] op, logic reply, logic [31:0] stamp);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        reply_ready <= reply;
        ntp_seconds <= stamp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_beat(op, reply, stamp);
    endtask

    // Wait for every owed beat to come out, then let the pipeline settle
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tracker.expected_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_config(logic [15:0] tmo, logic [2:0] retry, logic [4:0] zone,
                              logic [31:0] epoch);
        logic [CFG_DATA_W-1:0] vals[4];
        logic [CFG_IDX_W-1:0]  idxs[4];

        vals = '{CFG_DATA_W'(tmo), CFG_DATA_W'(retry), CFG_DATA_W'(zone), epoch};
        idxs = '{REG_REPLY_TIMEOUT, REG_MAX_RETRIES, REG_UTC_OFFSET, REG_EPOCH_OFFSET};
        drain();
        for (int i = 0; i < 4; i++)
        begin
            @(negedge clk);
            cfg_write <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data <= vals[i];
            tracker.write_reg(idxs[i], vals[i]);
        end
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // NTP stamp that lands `lead` seconds before local midnight on the given
    // day of the week (0 = Monday) under the current zone and epoch. A week
    // of margin keeps the subtraction from wrapping for zones past 23.
    function automatic logic [31:0] midnight_stamp(int day, int lead);
        logic [31:0] local_t;

        local_t = (day + 8) * DAY_SECONDS - lead;
        return local_t - tracker.zone_hours * 3600 + tracker.epoch_base;
    endfunction

    // Step the sequencer into the wait state; a pending midnight wait is
    // always close to midnight, so the ticks stay few.
    task automatic reach_wait();
        while (tracker.seq != SEQ_WAIT)
        begin
            if (tracker.seq == SEQ_MIDNIGHT && !tracker.rollover)
                push_beat(CMD_SEC_TICK, 1'b0, 32'h0);
            else
                push_beat(CMD_POLL, 1'b0, 32'h0);
        end
    endtask

    // One random beat, shaped by where the sequencer is so that request /
    // timeout / retry / reply / midnight cycles keep turning over.
    task automatic random_beat();
        int          roll;
        logic        reply;
        logic [31:0] stamp;
        logic [1:0]  noise;

        roll = $urandom_range(99);
        reply = 1'($urandom_range(1));
        stamp = $urandom();
        noise = 2'($urandom_range(3));
        case (tracker.seq)
            SEQ_SEND:
            begin
                if (roll < 70)
                    push_beat(CMD_POLL, reply, stamp);
                else
                    push_beat(noise, reply, stamp);
            end
            SEQ_WAIT:
            begin
                // replies land just before a local midnight and are forced
                // once retries are spent, so midnight is always a few ticks off
                reply = ($urandom_range(99) < 25) ||
                        (tracker.retries >= tracker.retry_limit);
                stamp = midnight_stamp($urandom_range(6), $urandom_range(1, 40));
                if (roll < 45)
                    push_beat(CMD_MS_TICK, reply, stamp);
                else if (roll < 85)
                    push_beat(CMD_POLL, reply, stamp);
                else
                    push_beat(noise, reply, stamp);
            end
            default:
            begin
                if (tracker.rollover && roll < 60)
                    push_beat(CMD_POLL, reply, stamp);
                else if (roll < 65)
                    push_beat(CMD_SEC_TICK, reply, stamp);
                else
                    push_beat(noise, reply, stamp);
            end
        endcase
    endtask

    initial
    begin
        tracker = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // --- reset config ---
        push_beat(CMD_UNUSED, 1'b1, 32'hFFFF_FFFF);
        push_beat(CMD_POLL, 1'b1, 32'h0);           // request; reply outside wait ignored
        push_beat(CMD_MS_TICK, 1'b0, 32'h0);
        push_beat(CMD_POLL, 1'b0, 32'h0);           // waiting, not timed out
        push_beat(CMD_POLL, 1'b1, midnight_stamp(6, 2));    // load Sunday 23:59:58
        push_beat(CMD_POLL, 1'b1, 32'h0);           // no midnight yet: reply ignored
        repeat (3) push_beat(CMD_SEC_TICK, 1'b0, 32'h0);    // Sunday wraps to Monday
        push_beat(CMD_POLL, 1'b0, 32'h0);           // midnight seen -> send state
        push_beat(CMD_POLL, 1'b0, 32'h0);           // request again

        // --- zero timeout, one retry, zone 31, zero epoch ---
        set_config(16'd0, 3'd1, 5'd31, 32'h0);
        push_beat(CMD_POLL, 1'b0, 32'h0);           // elapsed 0 is not past 0
        push_beat(CMD_MS_TICK, 1'b0, 32'h0);
        push_beat(CMD_POLL, 1'b0, 32'h0);           // timeout, retry left -> resend
        push_beat(CMD_POLL, 1'b0, 32'h0);
        push_beat(CMD_POLL, 1'b1, 32'd61198);       // zone 31 wraps hour and day
        repeat (2) push_beat(CMD_SEC_TICK, 1'b0, 32'h0);
        push_beat(CMD_POLL, 1'b0, 32'h0);

        // --- timeout that never expires, max retries, all-ones epoch ---
        set_config(16'hFFFF, 3'd7, 5'd0, 32'hFFFF_FFFF);
        push_beat(CMD_POLL, 1'b0, 32'h0);
        quiet = 1'b1;
        repeat (40) push_beat(CMD_MS_TICK, 1'($urandom_range(1)), $urandom());
        quiet = 1'b0;
        push_beat(CMD_POLL, 1'b0, 32'h0);           // far below the limit, still waiting
        push_beat(CMD_POLL, 1'b1, midnight_stamp(6, 5));

        // --- random phases, each with its own config ---
        for (int p = 0; p < 5; p++)
        begin
            if (p == 0)
                set_config(16'($urandom_range(8)), 3'd7, 5'($urandom_range(23)),
                           RST_EPOCH_OFFSET);
            else
                set_config((p == 4) ? 16'($urandom_range(20, 60)) : 16'($urandom_range(12)),
                           3'($urandom_range(7)), 5'($urandom_range(31)), $urandom());
            hold_req = 1'b1;
            quiet = (p == 2);
            repeat (240) random_beat();
            quiet = 1'b0;
        end

        // --- timeout with no retries allowed ---
        set_config(16'd0, 3'd0, tracker.zone_hours, tracker.epoch_base);
        reach_wait();
        push_beat(CMD_MS_TICK, 1'b0, 32'h0);
        push_beat(CMD_POLL, 1'b0, 32'h0);           // timeout -> wait for midnight
        push_beat(CMD_POLL, 1'b1, midnight_stamp(0, 3));    // reply ignored there

        drain();
        repeat (20) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
src/ntpc_pkg.sv
src/ntpc_conv.sv
src/ntp_synced_time_of_day_clock_core.sv
bench/ntp_synced_time_of_day_clock_core_tb.sv
